// ===== rtl/sequential_list_engine_unit_assert.svh =====
// Assertion macros for the sequential list engine.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLE_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLE_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/sle_pkg.sv =====
// Shared types and codes for the sequential list engine.
// No dependencies; used by sle_cell and sequential_list_engine_unit.
package sle_pkg;

  localparam int PosW = 6;
  localparam int ValW = 32;

  // Request modes.
  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_LOCATE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]             mode;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                   status;
    logic signed [ValW-1:0] value_out;
    logic                   found;
    logic [PosW-1:0]        found_position;
    logic [PosW-1:0]        list_length;
  } rsp_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_PROBE,
    CELL_STEP,
    CELL_STOP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_cmd_t;

endpackage

// ===== rtl/sequential_list_engine_unit.sv =====
// Sequential list engine: an ordered list of up to CAPACITY signed words kept
// in a chain of cells. Read, insert, delete and clear need no busy cycle and
// may be issued back to back; a locate holds busy high while a token walks the
// chain one cell per cycle, until it reaches the first match or passes the end
// of the list of n entries, which is a miss. Each result is shown for one cycle
// with done, in the cycle after the request is taken or after a locate's last busy
// cycle; the receiver cannot stall it.
// Depends on sle_pkg, sle_cell and sequential_list_engine_unit_assert.svh.
`include "sequential_list_engine_unit_assert.svh"

module sequential_list_engine_unit #(
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sle_pkg::req_t req,
  output logic          done,
  output sle_pkg::rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW = ((CW > sle_pkg::PosW) ? CW : sle_pkg::PosW) + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] scan, scan_next;
  logic          done_next;
  sle_pkg::rsp_t rsp_next;

  sle_pkg::cell_cmd_t cmd;
  logic [IW-1:0]      idx;
  logic [XW-1:0]      posx, cntx;
  logic               rd_ok, ins_ok, any_hit;

  logic signed [sle_pkg::ValW-1:0] cell_data  [CAPACITY];
  logic signed [sle_pkg::ValW-1:0] cell_left  [CAPACITY];
  logic signed [sle_pkg::ValW-1:0] cell_right [CAPACITY];
  logic [CAPACITY-1:0]             cell_ltok;
  logic [CAPACITY-1:0]             cell_tok;
  logic [CAPACITY-1:0]             cell_hit;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign cell_left[g] = req.value_in;
        assign cell_ltok[g] = 1'b0;
      end else begin : g_body
        assign cell_left[g] = cell_data[g-1];
        assign cell_ltok[g] = cell_tok[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign cell_right[g] = cell_data[g];
      end else begin : g_mid
        assign cell_right[g] = cell_data[g+1];
      end

      sle_cell #(
        .INDEX_W (IW),
        .INDEX   (g)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .idx        (idx),
        .value      (req.value_in),
        .left_data  (cell_left[g]),
        .right_data (cell_right[g]),
        .left_tok   (cell_ltok[g]),
        .data       (cell_data[g]),
        .tok        (cell_tok[g]),
        .hit        (cell_hit[g])
      );
    end
  endgenerate

  assign busy    = (state == ST_SCAN);
  assign any_hit = |cell_hit;

  assign posx   = XW'(req.position);
  assign cntx   = XW'(count);
  assign idx    = IW'(posx - XW'(1));
  assign rd_ok  = (posx != '0) && (posx <= cntx);
  assign ins_ok = (count != CW'(CAPACITY)) && (posx != '0) && (posx <= cntx + XW'(1));

  always_comb begin
    state_next = state;
    count_next = count;
    scan_next  = scan;
    done_next  = 1'b0;
    rsp_next   = '0;
    cmd.op     = sle_pkg::CELL_HOLD;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          unique case (req.mode)
            sle_pkg::MODE_READ: begin
              if (rd_ok) begin
                rsp_next.value_out = cell_data[idx];
              end else begin
                rsp_next.status = 1'b1;
              end
            end
            sle_pkg::MODE_INSERT: begin
              if (ins_ok) begin
                cmd.op     = sle_pkg::CELL_INSERT;
                count_next = count + CW'(1);
              end else begin
                rsp_next.status = 1'b1;
              end
            end
            sle_pkg::MODE_DELETE: begin
              if (rd_ok) begin
                cmd.op             = sle_pkg::CELL_DELETE;
                rsp_next.value_out = cell_data[idx];
                count_next         = count - CW'(1);
              end else begin
                rsp_next.status = 1'b1;
              end
            end
            sle_pkg::MODE_LOCATE: begin
              cmd.op     = sle_pkg::CELL_PROBE;
              done_next  = 1'b0;
              scan_next  = '0;
              state_next = ST_SCAN;
            end
            sle_pkg::MODE_CLEAR: begin
              count_next = '0;
            end
            default: begin
              rsp_next.status = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Once the token has passed the end of the list its cell is ignored.
        if (scan == count) begin
          cmd.op          = sle_pkg::CELL_STOP;
          done_next       = 1'b1;
          rsp_next.status = 1'b1;
          state_next      = ST_IDLE;
        end else if (any_hit) begin
          cmd.op                  = sle_pkg::CELL_STOP;
          done_next               = 1'b1;
          rsp_next.found          = 1'b1;
          rsp_next.found_position = sle_pkg::PosW'(scan + CW'(1));
          state_next              = ST_IDLE;
        end else begin
          cmd.op    = sle_pkg::CELL_STEP;
          scan_next = scan + CW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    rsp_next.list_length = sle_pkg::PosW'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      scan  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      scan  <= scan_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  `SLE_ASSERT_NOW(a_count_cap, 1'b1, count <= CW'(CAPACITY), "entry count above capacity")
  `SLE_ASSERT_NOW(a_tok_single, 1'b1, $onehot0(cell_tok), "more than one search token")
  `SLE_ASSERT_NOW(a_busy_no_done, busy, !done, "word delivered during a search")
  `SLE_ASSERT_NEXT(a_quick_done, start && !busy && (req.mode != sle_pkg::MODE_LOCATE), done,
                   "single-cycle request gave no word")

endmodule

// ===== rtl/sle_cell.sv =====
// One storage cell of the list chain: holds an entry, shifts with its
// neighbors on insert and delete, and passes the search token. Uses sle_pkg.
module sle_cell #(
  parameter int INDEX_W = 5,
  parameter int INDEX   = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sle_pkg::cell_cmd_t             cmd,
  input  logic [INDEX_W-1:0]             idx,
  input  logic signed [sle_pkg::ValW-1:0] value,
  input  logic signed [sle_pkg::ValW-1:0] left_data,
  input  logic signed [sle_pkg::ValW-1:0] right_data,
  input  logic                           left_tok,
  output logic signed [sle_pkg::ValW-1:0] data,
  output logic                           tok,
  output logic                           hit
);

  localparam logic [INDEX_W-1:0] MyIdx = INDEX_W'(INDEX);

  logic match;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      sle_pkg::CELL_INSERT: begin
        if (MyIdx > idx) begin
          data <= left_data;
        end else if (MyIdx == idx) begin
          data <= value;
        end
      end
      sle_pkg::CELL_DELETE: begin
        if (MyIdx >= idx) begin
          data <= right_data;
        end
      end
      sle_pkg::CELL_PROBE: begin
        match <= (data == value);
      end
      default: begin
      end
    endcase
  end

  // The token starts at the head cell and moves one cell per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      unique case (cmd.op)
        sle_pkg::CELL_PROBE: tok <= (INDEX == 0);
        sle_pkg::CELL_STEP:  tok <= left_tok;
        sle_pkg::CELL_STOP:  tok <= 1'b0;
        default:             tok <= tok;
      endcase
    end
  end

  assign hit = tok & match;

endmodule
